### rtl/mfih_pkg.sv
// Package for the integer mode histogram unit: widths, codes, queue entry
// and control types shared by the front, queue, back and checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfih_pkg;

   localparam int DefValueSpan  = 1024;
   localparam int DefCountWidth = 16;
   localparam int SampleWidth   = 11;
   localparam int IndexWidth    = 10;
   localparam int MaxSpan       = 1024;   // table entries for magnitudes 0..1023 of an 11-bit sample
   localparam int OutCountWidth = 16;
   localparam int QueueDepth    = 4;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_POS  = 2'd1,
      KIND_NEG  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic                    err;
      logic                    last;
      logic [IndexWidth-1:0]   index;
   } queue_entry_type;

   typedef enum logic [2:0] {
      BACK_CLEAR,
      BACK_COUNT,
      BACK_DRAIN,
      BACK_SCAN,
      BACK_TALLY,
      BACK_RESULT
   } back_state_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

### rtl/mfih_front.sv
// Front end: request handshake, skip_missing register and classification
// of each request into a queue entry. Depends on mfih_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfih_front
   import mfih_pkg::*;
#(
   parameter int VALUE_SPAN = DefValueSpan
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire signed [SampleWidth-1:0] req_sample,
   input  wire                          req_missing,
   input  wire                          req_last,
   input  wire                          csr_wr_en,
   input  wire                          csr_wr_data,
   input  wire                          q_full,
   input  back_status_type              back_status,
   output logic                         q_push,
   output queue_entry_type              q_entry
);

   localparam int ScanDepth = (VALUE_SPAN < MaxSpan) ? VALUE_SPAN : MaxSpan;

   logic                   skip_ff;
   logic                   skip_in;
   logic [SampleWidth-1:0] raw;
   logic [SampleWidth-1:0] neg_mag;

   assign skip_in = csr_wr_en ? csr_wr_data : skip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b1;
      end else begin
         skip_ff <= skip_in;
      end
   end

   assign req_ready = !q_full && !back_status.clearing;
   assign q_push    = req_valid && req_ready;

   assign raw     = $unsigned(req_sample);
   assign neg_mag = SampleWidth'(0) - raw;

   always_comb begin
      q_entry.last  = req_last;
      q_entry.kind  = KIND_NONE;
      q_entry.err   = 1'b0;
      q_entry.index = raw[IndexWidth-1:0];
      if (req_missing) begin
         q_entry.err = !skip_ff;
      end else if (raw[SampleWidth-1]) begin
         // -1024 lands here too: its magnitude is out of every table
         q_entry.index = neg_mag[IndexWidth-1:0];
         if (neg_mag >= SampleWidth'(ScanDepth)) begin
            q_entry.err = 1'b1;
         end else begin
            q_entry.kind = KIND_NEG;
         end
      end else begin
         if (raw >= SampleWidth'(ScanDepth)) begin
            q_entry.err = 1'b1;
         end else begin
            q_entry.kind = KIND_POS;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/mfih_queue.sv
// Short queue of classified requests between front and back.
// Depends on mfih_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfih_queue
   import mfih_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             push,
   input  queue_entry_type wr_entry,
   input  wire             pop,
   output queue_entry_type rd_entry,
   output logic            full,
   output logic            empty
);

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntWidth = $clog2(QueueDepth + 1);

   queue_entry_type      slot_ff [QueueDepth];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (cnt_ff == CntWidth'(QueueDepth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign rd_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

### rtl/mfih_back.sv
// Back end: count tables with read-modify-write and forwarding, the
// end-of-set scan that also clears, and the result register.
// Depends on mfih_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfih_back
   import mfih_pkg::*;
#(
   parameter int VALUE_SPAN  = DefValueSpan,
   parameter int COUNT_WIDTH = DefCountWidth
) (
   input  wire                           clock,
   input  wire                           reset,
   input  queue_entry_type               q_entry,
   input  wire                           q_empty,
   output logic                          q_pop,
   output back_status_type               back_status,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic signed [SampleWidth-1:0] rsp_mode_value,
   output logic [OutCountWidth-1:0]      rsp_mode_count,
   output logic [1:0]                    rsp_status
);

   localparam int ScanDepth = (VALUE_SPAN < MaxSpan) ? VALUE_SPAN : MaxSpan;
   localparam int IW        = $clog2(ScanDepth);
   localparam int CW        = COUNT_WIDTH;

   // count tables
   logic [CW-1:0] pos_mem [ScanDepth];
   logic [CW-1:0] neg_mem [ScanDepth];
   logic [CW-1:0] pos_rdata_ff;
   logic [CW-1:0] neg_rdata_ff;
   logic [IW-1:0] raddr;
   logic [IW-1:0] waddr;
   logic [CW-1:0] wdata;
   logic          pos_we;
   logic          neg_we;

   back_state_type state_ff, state_in;
   logic [IW-1:0]  addr_ff, addr_in;

   // update stage and last write, for forwarding
   logic           s1_valid_ff, s1_valid_in;
   kind_type       s1_kind_ff, s1_kind_in;
   logic [IW-1:0]  s1_idx_ff, s1_idx_in;
   logic           wr_valid_ff;
   kind_type       wr_kind_ff;
   logic [IW-1:0]  wr_idx_ff;
   logic [CW-1:0]  wr_data_ff;
   logic [CW-1:0]  base;
   logic [CW-1:0]  bumped;

   logic           any_ff, any_in;
   logic           err_ff, err_in;

   // scan compare stage
   logic           scan_valid_ff, scan_valid_in;
   logic [IW-1:0]  scan_idx_ff;
   logic [CW-1:0]  best_pos_ff, best_pos_in;
   logic [IW-1:0]  best_pos_idx_ff, best_pos_idx_in;
   logic [CW-1:0]  best_neg_ff, best_neg_in;
   logic [IW-1:0]  best_neg_idx_ff, best_neg_idx_in;

   // result
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SampleWidth-1:0] rsp_value_ff, rsp_value_in;
   logic [OutCountWidth-1:0] rsp_count_ff, rsp_count_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   load;
   logic [CW-1:0]          win_count;
   logic [OutCountWidth-1:0] win_count_sat;
   logic                   sweep;

   assign back_status.clearing = (state_ff == BACK_CLEAR);

   assign q_pop = (state_ff == BACK_COUNT) && !q_empty;
   assign sweep = (state_ff == BACK_CLEAR) || (state_ff == BACK_SCAN);
   assign raddr = (state_ff == BACK_COUNT) ? q_entry.index[IW-1:0] : addr_ff;

   // saturating increment; the previous write forwards over the stale read
   always_comb begin
      if (wr_valid_ff && (wr_kind_ff == s1_kind_ff) && (wr_idx_ff == s1_idx_ff)) begin
         base = wr_data_ff;
      end else if (s1_kind_ff == KIND_NEG) begin
         base = neg_rdata_ff;
      end else begin
         base = pos_rdata_ff;
      end
      bumped = (&base) ? base : base + 1'b1;
   end

   assign waddr  = sweep ? addr_ff : s1_idx_ff;
   assign wdata  = sweep ? '0 : bumped;
   assign pos_we = sweep || (s1_valid_ff && (s1_kind_ff == KIND_POS));
   assign neg_we = sweep || (s1_valid_ff && (s1_kind_ff == KIND_NEG));

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[waddr] <= wdata;
      end
      if (neg_we) begin
         neg_mem[waddr] <= wdata;
      end
      pos_rdata_ff <= pos_mem[raddr];
      neg_rdata_ff <= neg_mem[raddr];
   end

   // winner and its count, saturated to the output width
   always_comb begin
      rsp_value_in = '0;
      win_count    = '0;
      if (any_ff) begin
         if (best_pos_ff > best_neg_ff) begin
            rsp_value_in = SampleWidth'(best_pos_idx_ff);
            win_count    = best_pos_ff;
         end else begin
            rsp_value_in = SampleWidth'(0) - SampleWidth'(best_neg_idx_ff);
            win_count    = best_neg_ff;
         end
      end
      if (err_ff) begin
         rsp_status_in = STATUS_ERROR;
      end else if (!any_ff) begin
         rsp_status_in = STATUS_EMPTY;
      end else begin
         rsp_status_in = STATUS_OK;
      end
   end

   if (CW > OutCountWidth) begin : g_sat
      assign win_count_sat = (|win_count[CW-1:OutCountWidth]) ? '1
                                                              : win_count[OutCountWidth-1:0];
   end else begin : g_nosat
      assign win_count_sat = OutCountWidth'(win_count);
   end

   assign rsp_count_in = win_count_sat;
   assign load         = (state_ff == BACK_RESULT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in        = state_ff;
      addr_in         = addr_ff;
      s1_valid_in     = 1'b0;
      s1_kind_in      = s1_kind_ff;
      s1_idx_in       = s1_idx_ff;
      any_in          = any_ff;
      err_in          = err_ff;
      scan_valid_in   = 1'b0;
      best_pos_in     = best_pos_ff;
      best_pos_idx_in = best_pos_idx_ff;
      best_neg_in     = best_neg_ff;
      best_neg_idx_in = best_neg_idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (scan_valid_ff) begin
         if (pos_rdata_ff > best_pos_ff) begin
            best_pos_in     = pos_rdata_ff;
            best_pos_idx_in = scan_idx_ff;
         end
         if (neg_rdata_ff > best_neg_ff) begin
            best_neg_in     = neg_rdata_ff;
            best_neg_idx_in = scan_idx_ff;
         end
      end

      unique case (state_ff)
         BACK_CLEAR: begin
            if (addr_ff == IW'(ScanDepth - 1)) begin
               addr_in  = '0;
               state_in = BACK_COUNT;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         BACK_COUNT: begin
            if (q_pop) begin
               s1_valid_in = (q_entry.kind != KIND_NONE);
               s1_kind_in  = q_entry.kind;
               s1_idx_in   = q_entry.index[IW-1:0];
               any_in      = any_ff || (q_entry.kind != KIND_NONE);
               err_in      = err_ff || q_entry.err;
               if (q_entry.last) begin
                  state_in = BACK_DRAIN;
               end
            end
         end
         BACK_DRAIN: begin
            // last count lands this cycle; scan reads start after it
            addr_in         = '0;
            best_pos_in     = '0;
            best_pos_idx_in = '0;
            best_neg_in     = '0;
            best_neg_idx_in = '0;
            state_in        = BACK_SCAN;
         end
         BACK_SCAN: begin
            scan_valid_in = 1'b1;
            if (addr_ff == IW'(ScanDepth - 1)) begin
               addr_in  = '0;
               state_in = BACK_TALLY;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         BACK_TALLY: begin
            state_in = BACK_RESULT;
         end
         BACK_RESULT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               any_in       = 1'b0;
               err_in       = 1'b0;
               state_in     = BACK_COUNT;
            end
         end
         default: begin
            state_in = BACK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_CLEAR;
         addr_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         wr_valid_ff   <= 1'b0;
         any_ff        <= 1'b0;
         err_ff        <= 1'b0;
         scan_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         s1_valid_ff   <= s1_valid_in;
         wr_valid_ff   <= s1_valid_ff;
         any_ff        <= any_in;
         err_ff        <= err_in;
         scan_valid_ff <= scan_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff      <= s1_kind_in;
      s1_idx_ff       <= s1_idx_in;
      wr_kind_ff      <= s1_kind_ff;
      wr_idx_ff       <= s1_idx_ff;
      wr_data_ff      <= bumped;
      scan_idx_ff     <= addr_ff;
      best_pos_ff     <= best_pos_in;
      best_pos_idx_ff <= best_pos_idx_in;
      best_neg_ff     <= best_neg_in;
      best_neg_idx_ff <= best_neg_idx_in;
      if (load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode_value = $signed(rsp_value_ff);
   assign rsp_mode_count = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/most_frequent_integer_histogram_unit.sv
// Result: once a request marked last is accepted, the back end pops it, drains, reads
//   every table entry once in the scan, tallies, then registers the response and raises rsp_valid.
// Throughput: one request per cycle while counting (count table read-modify-write with
//   forwarding); the end-of-set scan holds the back end.
// Reset: a clearing pass over the tables with req_ready low; skip_missing = 1.
`timescale 1ns / 1ps
`default_nettype none

module most_frequent_integer_histogram_unit
   import mfih_pkg::*;
#(
   parameter int VALUE_SPAN  = DefValueSpan,
   parameter int COUNT_WIDTH = DefCountWidth
) (
   input  wire                           clock,
   input  wire                           reset,
   // request channel
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire signed [SampleWidth-1:0]  req_sample,
   input  wire                           req_missing,
   input  wire                           req_last,
   // response channel
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic signed [SampleWidth-1:0] rsp_mode_value,
   output logic [OutCountWidth-1:0]      rsp_mode_count,
   output logic [1:0]                    rsp_status,
   // skip_missing register
   input  wire                           csr_wr_en,
   input  wire                           csr_wr_data
);

   // Front: takes each request, sorts it into positive count, negative count
   // (by magnitude) or nothing, and marks out-of-range values and unskipped
   // missing requests as errors.
   queue_entry_type front_entry;
   queue_entry_type back_entry;
   logic            q_push;
   logic            q_pop;
   logic            q_full;
   logic            q_empty;
   back_status_type back_status;

   mfih_front #(
      .VALUE_SPAN (VALUE_SPAN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .req_missing (req_missing),
      .req_last    (req_last),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .back_status (back_status),
      .q_push      (q_push),
      .q_entry     (front_entry)
   );

   // Queue: lets the front keep taking requests of the next set while the
   // back end scans the tables.
   mfih_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (front_entry),
      .pop      (q_pop),
      .rd_entry (back_entry),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Back: counts into the two tables; after the last request it sweeps both
   // tables once, finding the first maximum of each and zeroing as it goes,
   // then the negative side wins ties and the response is registered.
   mfih_back #(
      .VALUE_SPAN  (VALUE_SPAN),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_entry        (back_entry),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .back_status    (back_status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mode_value (rsp_mode_value),
      .rsp_mode_count (rsp_mode_count),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

### rtl/mfih_checker.sv
// Port-level checks for the integer mode histogram unit, bound to the top.
// Depends on mfih_pkg and most_frequent_integer_histogram_unit.
`timescale 1ns / 1ps
`default_nettype none

module mfih_checker
   import mfih_pkg::*;
(
   input wire                          clock,
   input wire                          reset,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire signed [SampleWidth-1:0] rsp_mode_value,
   input wire [OutCountWidth-1:0]      rsp_mode_count,
   input wire [1:0]                    rsp_status
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode_value)
                                  && $stable(rsp_mode_count) && $stable(rsp_status))
      else $error("response changed while stalled");

   // empty set reports zero value and count
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> (rsp_mode_value == '0)
                                                    && (rsp_mode_count == '0))
      else $error("empty set with nonzero mode");

   // a clean set always counted something
   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) |-> (rsp_mode_count != '0))
      else $error("ok status with zero count");

   // tables are being cleared right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind most_frequent_integer_histogram_unit mfih_checker u_checker (.*);

`default_nettype wire

### tb/mfih_mode_checker.sv
// Response checker for the integer mode histogram unit: mirrors both count
// tables, predicts the mode response of each set and compares it with the DUT.
// Depends on mfih_pkg.
`timescale 1ns / 1ps

module mfih_mode_checker
   import mfih_pkg::*;
#(
   parameter int VALUE_SPAN  = DefValueSpan,
   parameter int COUNT_WIDTH = DefCountWidth
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_ready,
   input  wire signed [SampleWidth-1:0] req_sample,
   input  wire                          req_missing,
   input  wire                          req_last,
   input  wire                          rsp_valid,
   input  wire                          rsp_ready,
   input  wire signed [SampleWidth-1:0] rsp_mode_value,
   input  wire [OutCountWidth-1:0]      rsp_mode_count,
   input  wire [1:0]                    rsp_status,
   input  wire                          csr_wr_en,
   input  wire                          csr_wr_data,
   output int                           failure_count,
   output int                           pending_results
);

   localparam longint unsigned TallyCap = (64'd1 << COUNT_WIDTH) - 1;
   localparam longint unsigned OutCap   = (64'd1 << OutCountWidth) - 1;

   typedef struct {
      logic signed [SampleWidth-1:0] value;
      logic [OutCountWidth-1:0]      count;
      status_type                    status;
   } mode_result_type;

   longint unsigned pos_tally [VALUE_SPAN];
   longint unsigned neg_tally [VALUE_SPAN];
   bit              any_counted  = 1'b0;
   bit              error_seen   = 1'b0;
   bit              skip_missing = 1'b1;
   mode_result_type mode_results_due [$];
   int              mismatches   = 0;
   int              due_count    = 0;
   int              responses    = 0;

   assign failure_count   = mismatches;
   assign pending_results = due_count;

   function automatic void clear_tallies();
      for (int i = 0; i < VALUE_SPAN; i++) begin
         pos_tally[i] = 0;
         neg_tally[i] = 0;
      end
      any_counted = 1'b0;
      error_seen  = 1'b0;
   endfunction

   // Counts one request; on the closing request of a set it scans both
   // tables, fills in the mode response and starts a fresh set.
   function automatic bit tally_request(input logic signed [SampleWidth-1:0] sample,
                                        input logic is_missing, input logic is_last,
                                        output mode_result_type res);
      int              value;
      int              mag;
      int              pos_where;
      int              neg_where;
      longint unsigned pos_top;
      longint unsigned neg_top;
      longint unsigned hits;
      value = sample;
      if (is_missing) begin
         if (!skip_missing) error_seen = 1'b1;
      end else if (value < 0) begin
         mag = -value;
         if (mag >= MaxSpan || mag >= VALUE_SPAN) begin
            error_seen = 1'b1;
         end else begin
            if (neg_tally[mag] < TallyCap) neg_tally[mag]++;
            any_counted = 1'b1;
         end
      end else if (value >= VALUE_SPAN) begin
         error_seen = 1'b1;
      end else begin
         if (pos_tally[value] < TallyCap) pos_tally[value]++;
         any_counted = 1'b1;
      end
      if (!is_last) return 1'b0;

      pos_where = 0;
      neg_where = 0;
      pos_top   = 0;
      neg_top   = 0;
      hits      = 0;
      value     = 0;
      if (any_counted) begin
         // strict compare keeps the smallest magnitude on equal counts
         for (int i = 0; i < VALUE_SPAN; i++) begin
            if (pos_tally[i] > pos_top) begin
               pos_top   = pos_tally[i];
               pos_where = i;
            end
            if (neg_tally[i] > neg_top) begin
               neg_top   = neg_tally[i];
               neg_where = i;
            end
         end
         // negative side takes ties
         if (pos_top > neg_top) begin
            value = pos_where;
            hits  = pos_top;
         end else begin
            value = -neg_where;
            hits  = neg_top;
         end
      end
      res.value = value[SampleWidth-1:0];
      res.count = (hits > OutCap) ? '1 : hits[OutCountWidth-1:0];
      if (error_seen)        res.status = STATUS_ERROR;
      else if (!any_counted) res.status = STATUS_EMPTY;
      else                   res.status = STATUS_OK;
      clear_tallies();
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      mode_result_type fresh;
      mode_result_type oldest;
      if (reset) begin
         clear_tallies();
         skip_missing = 1'b1;
         mode_results_due.delete();
      end else begin
         if (csr_wr_en) skip_missing = csr_wr_data;
         if (req_valid && req_ready) begin
            if (tally_request(req_sample, req_missing, req_last, fresh))
               mode_results_due = {mode_results_due, fresh};
         end
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (mode_results_due.size() == 0) begin
               if (mismatches < 10)
                  $display("response %0d: none expected, got value %0d count %0d status %0d",
                           responses, rsp_mode_value, rsp_mode_count, rsp_status);
               mismatches++;
            end else begin
               oldest = mode_results_due.pop_front();
               if (rsp_mode_value !== oldest.value || rsp_mode_count !== oldest.count ||
                   rsp_status !== oldest.status) begin
                  if (mismatches < 10)
                     $display("response %0d: expected value %0d count %0d status %0d, %s %0d %s %0d %s %0d",
                              responses, oldest.value, oldest.count, oldest.status,
                              "got value", rsp_mode_value, "count", rsp_mode_count,
                              "status", rsp_status);
                  mismatches++;
               end
            end
         end
      end
      due_count <= mode_results_due.size();
   end

endmodule

### tb/tb_most_frequent_integer_histogram_unit.sv
// Testbench top for the integer mode histogram unit: clock, reset, request
// stimulus, response-side stalls and the verdict. Depends on mfih_pkg, the
// unit itself and mfih_mode_checker.
`timescale 1ns / 1ps

module tb_most_frequent_integer_histogram_unit;
   import mfih_pkg::*;

   // A set's response follows a full table scan after its closing request;
   // give the unit a margin beyond that scan before touching the CSR.
   localparam int SettleCycles = MaxSpan + 64;
   localparam int unsigned HoldCycles = 4000;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   logic signed [SampleWidth-1:0] req_sample  = '0;
   logic                          req_missing = 1'b0;
   logic                          req_last    = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   logic signed [SampleWidth-1:0] rsp_mode_value;
   logic [OutCountWidth-1:0]      rsp_mode_count;
   logic [1:0]                    rsp_status;
   logic                          csr_wr_en   = 1'b0;
   logic                          csr_wr_data = 1'b0;

   int          failure_count;
   int          pending_results;
   int          send_idle_pct  = 0;   // chance per request of an idle gap after it
   int          recv_stall_pct = 0;   // chance per cycle that rsp_ready drops
   int unsigned rsp_hold_left  = 0;   // cycles left in a forced response hold-off
   int          hold_starts    = 0;   // hold-offs asked for by the stimulus
   int          hold_taken     = 0;   // hold-offs started by the response side

   most_frequent_integer_histogram_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_missing    (req_missing),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mode_value (rsp_mode_value),
      .rsp_mode_count (rsp_mode_count),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   mfih_mode_checker mode_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_missing     (req_missing),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mode_value  (rsp_mode_value),
      .rsp_mode_count  (rsp_mode_count),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .failure_count   (failure_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop.
   initial begin
      #80_000_000;
      $display("tb_most_frequent_integer_histogram_unit: done, errors");
      $finish;
   end

   // Response side: a forced hold-off wins over the random stalls.
   always @(posedge clock) begin
      if (hold_taken != hold_starts) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= HoldCycles - 1;
         hold_taken    <= hold_starts;
      end else if (rsp_hold_left != 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offers one request and returns once req_ready reads high after an edge.
   // Valid stays up into the next request unless a random idle gap follows.
   task automatic offer_request(input int value, input bit is_missing, input bit is_last);
      int gap;
      req_valid   <= 1'b1;
      req_sample  <= value[SampleWidth-1:0];
      req_missing <= is_missing;
      req_last    <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One well-formed set with random content. Most sets draw from a small pool
   // so values repeat and ties between the tables happen; a few are spread over
   // the whole range, hug zero or are all missing. Returns the non-missing count.
   task automatic offer_random_set(output int counted);
      int len;
      int style;
      int v;
      int pool [4];
      bit is_missing;
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
      style = $urandom_range(0, 19);
      foreach (pool[j]) pool[j] = int'($urandom_range(0, 2046)) - 1023;
      counted = 0;
      for (int k = 0; k < len; k++) begin
         // style 19 is an all-missing set: empty or error depending on the CSR
         is_missing = (style == 19) || ($urandom_range(0, 99) < 6);
         if (is_missing)                      v = int'($urandom_range(0, 2047)) - 1024;
         else if ($urandom_range(0, 99) < 2)  v = -1024;   // the one out-of-range code
         else if (style < 12)                 v = pool[$urandom_range(0, 3)];
         else if (style < 16)                 v = int'($urandom_range(0, 6)) - 3;
         else                                 v = int'($urandom_range(0, 2047)) - 1024;
         if (!is_missing) counted++;
         offer_request(v, is_missing, k == len - 1);
      end
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int goal);
      int sent;
      int got;
      send_idle_pct = idle_pct;
      recv_stall_pct <= stall_pct;
      sent = 0;
      while (sent < goal) begin
         offer_random_set(got);
         sent += got;
      end
   endtask

   // Sender pause: nothing offered until every response is back and the
   // unit has waited out SettleCycles to go quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_skip_missing(input bit skip);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= skip;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic reconfigure(input bit skip);
      drain_results();
      write_skip_missing(skip);
   endtask

   initial begin
      int got;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed, missing requests flagged ---
      write_skip_missing(1'b0);
      // extremes on both sides with equal counts: negative side must win
      offer_request(1023, 1'b0, 1'b0);
      offer_request(-1023, 1'b0, 1'b0);
      offer_request(0, 1'b0, 1'b0);
      offer_request(-1023, 1'b0, 1'b0);
      offer_request(1023, 1'b0, 1'b1);
      // lone missing request: error beats empty, mode stays zero
      offer_request(-1, 1'b1, 1'b1);
      // out-of-range sample flags the set but the mode is still reported
      offer_request(-1024, 1'b0, 1'b0);
      offer_request(5, 1'b0, 1'b0);
      offer_request(5, 1'b0, 1'b0);
      offer_request(7, 1'b0, 1'b1);

      // --- directed, missing requests dropped ---
      reconfigure(1'b1);
      offer_request(-1, 1'b1, 1'b1);            // empty set
      offer_request(1, 1'b0, 1'b0);
      offer_request(-1, 1'b0, 1'b0);
      offer_request(1023, 1'b1, 1'b0);          // dropped silently
      offer_request(2, 1'b0, 1'b0);
      offer_request(2, 1'b0, 1'b0);
      offer_request(-2, 1'b0, 1'b0);
      offer_request(-2, 1'b0, 1'b1);
      // equal counts within one table: smallest magnitude wins
      offer_request(4, 1'b0, 1'b0);
      offer_request(4, 1'b0, 1'b0);
      offer_request(3, 1'b0, 1'b0);
      offer_request(3, 1'b0, 1'b1);

      // --- random sets under each idling mix ---
      reconfigure(1'b1);
      run_random_phase(0, 0, 270);
      reconfigure(1'b0);
      run_random_phase(49, 0, 270);
      reconfigure(1'b1);
      run_random_phase(0, 49, 270);
      reconfigure(1'b0);
      run_random_phase(12, 12, 270);

      // --- backpressure: hold responses long enough that the queue fills
      //     and req_ready drops while requests keep coming ---
      reconfigure(1'b1);
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      hold_starts++;
      repeat (4) offer_random_set(got);
      // a fixed set long enough to fill the queue behind a held response
      for (int k = 0; k < 8; k++) offer_request(k - 4, 1'b0, k == 7);

      // --- a flagged missing request inside a set that still has a mode ---
      reconfigure(1'b0);
      repeat (20) offer_request(-7, 1'b0, 1'b0);
      offer_request(300, 1'b1, 1'b0);
      offer_request(9, 1'b0, 1'b0);
      offer_request(9, 1'b0, 1'b0);
      offer_request(9, 1'b0, 1'b1);

      drain_results();
      if (failure_count == 0 && pending_results == 0) begin
         $display("tb_most_frequent_integer_histogram_unit: done, clean");
      end else begin
         $display("tb_most_frequent_integer_histogram_unit: done, errors");
      end
      $finish;
   end

endmodule

### files.f
rtl/mfih_pkg.sv
rtl/mfih_front.sv
rtl/mfih_queue.sv
rtl/mfih_back.sv
rtl/most_frequent_integer_histogram_unit.sv
rtl/mfih_checker.sv
tb/mfih_mode_checker.sv
tb/tb_most_frequent_integer_histogram_unit.sv
